/* rtl/core/lfu_pkg.sv */
// Shared constants and types for the LFU cache table.
package lfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int COUNT_BITS = 16;

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEAF_COUNT = 1 << IDX_BITS;
   localparam int OCC_BITS   = $clog2(CAPACITY + 1);
   localparam int CAP_BITS   = 5;
   localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
   localparam int DATA_BITS  = 32;
   localparam int ORDER_BITS = COUNT_BITS + IDX_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET        = CAP_BITS'(16);
   localparam logic                CSR_IDX_CAPACITY = 1'b0;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic                        command;
      logic signed [DATA_BITS-1:0] key;
      logic signed [DATA_BITS-1:0] value;
   } lfu_req_type;

   typedef struct packed {
      logic                        hit;
      logic signed [DATA_BITS-1:0] read_value;
      logic                        evicted;
      logic signed [DATA_BITS-1:0] evicted_key;
   } lfu_rsp_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } lfu_victim_type;

   typedef struct packed {
      logic                  valid;
      logic [ORDER_BITS-1:0] order;
      logic [IDX_BITS-1:0]   idx;
   } lfu_node_type;

endpackage

/* rtl/core/lfu_victim_select.sv */
// Comparison tree that picks the lowest-count, least recent valid entry.
module lfu_victim_select (
   input  logic [lfu_pkg::CAPACITY-1:0]                           valid,
   input  logic [lfu_pkg::CAPACITY-1:0][lfu_pkg::COUNT_BITS-1:0]  count,
   input  logic [lfu_pkg::CAPACITY-1:0][lfu_pkg::IDX_BITS-1:0]    rank,
   output lfu_pkg::lfu_victim_type                                victim
);
   import lfu_pkg::*;

   lfu_node_type node [2*LEAF_COUNT];

   // Leaves sit at LEAF_COUNT and above; the ordering key is count first, then
   // inverted rank so that the older entry wins a tie on count.
   always_comb begin
      node[0] = '0;
      for (int i = 0; i < LEAF_COUNT; i++) begin
         if (i < CAPACITY) begin
            node[LEAF_COUNT+i].valid = valid[i];
            node[LEAF_COUNT+i].order = {count[i], ~rank[i]};
         end else begin
            node[LEAF_COUNT+i].valid = 1'b0;
            node[LEAF_COUNT+i].order = '0;
         end
         node[LEAF_COUNT+i].idx = IDX_BITS'(i);
      end
      for (int j = LEAF_COUNT - 1; j >= 1; j--) begin
         if (node[2*j].valid &&
             (!node[2*j+1].valid || node[2*j].order <= node[2*j+1].order)) begin
            node[j] = node[2*j];
         end else begin
            node[j] = node[2*j+1];
         end
      end
   end

   assign victim.found = node[1].valid;
   assign victim.idx   = node[1].idx;

endmodule

/* rtl/core/lfu_table_store.sv */
// Entry storage with key match, use counts, recency ranks and replacement.
module lfu_table_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  lfu_pkg::lfu_req_type          req,
   input  logic [lfu_pkg::CAP_BITS-1:0]  capacity,
   output lfu_pkg::lfu_rsp_type          rsp
);
   import lfu_pkg::*;

   logic [CAPACITY-1:0]                   valid_ff, valid_in;
   logic [CAPACITY-1:0][DATA_BITS-1:0]    key_ff, key_in;
   logic [CAPACITY-1:0][DATA_BITS-1:0]    value_ff, value_in;
   logic [CAPACITY-1:0][COUNT_BITS-1:0]   count_ff, count_in;
   logic [CAPACITY-1:0][IDX_BITS-1:0]     rank_ff, rank_in;

   logic [CAPACITY-1:0]   match;
   logic                  hit;
   logic [IDX_BITS-1:0]   hit_idx;
   logic [DATA_BITS-1:0]  hit_value;
   logic [IDX_BITS-1:0]   hit_rank;
   logic [OCC_BITS-1:0]   occupancy;
   logic [CMP_BITS-1:0]   cap_ext;
   logic [CMP_BITS-1:0]   cap_eff;
   logic                  do_put;
   logic                  do_touch;
   logic                  do_miss_put;
   logic                  need_evict;
   logic [CAPACITY-1:0]   free_mask;
   logic                  do_insert;
   logic [IDX_BITS-1:0]   slot;
   logic [IDX_BITS-1:0]   victim_rank;
   lfu_victim_type        victim;

   lfu_victim_select u_victim (
      .valid  (valid_ff),
      .count  (count_ff),
      .rank   (rank_ff),
      .victim (victim)
   );

   always_comb begin
      hit_idx   = '0;
      hit_value = '0;
      occupancy = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == req.key);
         hit_idx   = hit_idx | (match[i] ? IDX_BITS'(i) : '0);
         hit_value = hit_value | (match[i] ? value_ff[i] : '0);
         occupancy = occupancy + OCC_BITS'(valid_ff[i]);
      end
      hit = |match;
   end

   assign hit_rank    = rank_ff[hit_idx];
   assign victim_rank = rank_ff[victim.idx];

   assign cap_ext = CMP_BITS'(capacity);
   assign cap_eff = (cap_ext > CMP_BITS'(CAPACITY)) ? CMP_BITS'(CAPACITY) : cap_ext;

   assign do_put      = req_valid && (req.command == CMD_PUT) && (cap_eff != '0);
   assign do_touch    = req_valid && hit && ((req.command == CMD_GET) || do_put);
   assign do_miss_put = do_put && !hit;
   assign need_evict  = do_miss_put && (CMP_BITS'(occupancy) >= cap_eff) && victim.found;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         free_mask[i] = !valid_ff[i] || (need_evict && (victim.idx == IDX_BITS'(i)));
      end
      slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            slot = IDX_BITS'(i);
         end
      end
   end

   assign do_insert = do_miss_put && (|free_mask);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_touch) begin
            if (hit_idx == IDX_BITS'(i)) begin
               rank_in[i] = '0;
               if (count_ff[i] != '1) begin
                  count_in[i] = count_ff[i] + COUNT_BITS'(1);
               end
               if (req.command == CMD_PUT) begin
                  value_in[i] = req.value;
               end
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_BITS'(1);
            end
         end
         if (do_insert) begin
            if (slot == IDX_BITS'(i)) begin
               valid_in[i] = 1'b1;
               key_in[i]   = req.key;
               value_in[i] = req.value;
               count_in[i] = COUNT_BITS'(1);
               rank_in[i]  = '0;
            end else if (need_evict && (victim.idx == IDX_BITS'(i))) begin
               valid_in[i] = 1'b0;
            end else if (valid_ff[i]) begin
               if (need_evict && (rank_ff[i] > victim_rank)) begin
                  rank_in[i] = rank_ff[i];
               end else begin
                  rank_in[i] = rank_ff[i] + IDX_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

   assign rsp.hit         = hit;
   assign rsp.read_value  = ((req.command == CMD_GET) && hit) ? hit_value : '1;
   assign rsp.evicted     = need_evict;
   assign rsp.evicted_key = need_evict ? key_ff[victim.idx] : '0;

endmodule

/* rtl/core/lfu_cache_table.sv */
// Top level of the LFU cache table: request and result registers, CSR port.
//
// A request (get or put of a key and value) is accepted at a clock edge where
// start is high and busy is low. busy stays low, so one request can be taken
// in every cycle. The request is registered, the table is searched and
// updated at the next edge; from then the result is shown on the rsp_ ports,
// with rsp_strobe high for a single cycle.
// Back-to-back requests see each other's updates in order.
// Throughput is one request per cycle; the path from the request register
// through the parallel key compare and the victim comparison tree to the
// table registers sets the cycle time.
// The receiver cannot stall: each result is valid for one cycle only.
// The capacity register sits at byte address 0 of the APB-style port and
// may only be written while no request is in flight.
// Synchronous reset empties the table, drops any request in flight and sets
// the capacity to 16.
module lfu_cache_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] req_key,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] req_value,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic signed [lfu_pkg::DATA_BITS-1:0] rsp_read_value,
   output logic                                rsp_evicted,
   output logic signed [lfu_pkg::DATA_BITS-1:0] rsp_evicted_key,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lfu_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [lfu_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [lfu_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   import lfu_pkg::*;

   logic                 req_valid_ff;
   lfu_req_type          req_ff;
   logic                 rsp_strobe_ff;
   lfu_rsp_type          rsp_ff;
   lfu_rsp_type          rsp_in;
   logic [CAP_BITS-1:0]  capacity_ff;
   logic                 accept;
   logic                 csr_write;
   logic                 csr_hit_capacity;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pready           = 1'b1;
   assign csr_hit_capacity = (paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_CAPACITY);
   assign csr_write        = psel && penable && pwrite && pready && csr_hit_capacity;
   assign prdata = csr_hit_capacity ? CSR_DATA_BITS'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            capacity_ff <= pwdata[CAP_BITS-1:0];
         end
         req_valid_ff  <= accept;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.command <= req_command;
         req_ff.key     <= req_key;
         req_ff.value   <= req_value;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   lfu_table_store u_table (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .capacity  (capacity_ff),
      .rsp       (rsp_in)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_evicted     = rsp_ff.evicted;
   assign rsp_evicted_key = rsp_ff.evicted_key;

endmodule

/* rtl/core/lfu_chk.sv */
// Port-level checker for the LFU cache table and its bind statement.
module lfu_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic                                rsp_hit,
   input logic signed [lfu_pkg::DATA_BITS-1:0] rsp_read_value,
   input logic                                rsp_evicted,
   input logic signed [lfu_pkg::DATA_BITS-1:0] rsp_evicted_key
);
   import lfu_pkg::*;

   // Every accepted request is followed by a result strobe.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("accepted request produced no result");

   // An eviction only happens on a put of a key that was absent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_evicted |-> !rsp_hit && (rsp_read_value == '1))
      else $error("eviction reported on a hit or a get");

   // The evicted key reads as zero when nothing was evicted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key nonzero without an eviction");

   // A miss never returns stored data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> rsp_read_value == '1)
      else $error("miss returned a value");

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (.*);

/* verif/lfu_table_checker.sv */
// Checker for the LFU cache table: predicts each result and compares it with the block's output.
`timescale 1ns / 100ps

module lfu_table_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 req_command,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] req_key,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] req_value,
   input  logic                                 rsp_strobe,
   input  logic                                 rsp_hit,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] rsp_read_value,
   input  logic                                 rsp_evicted,
   input  logic signed [lfu_pkg::DATA_BITS-1:0] rsp_evicted_key,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lfu_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [lfu_pkg::CSR_DATA_BITS-1:0]    pwdata,
   input  logic [lfu_pkg::CSR_DATA_BITS-1:0]    prdata,
   input  logic                                 pready,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   results_seen,
   output int                                   hits_seen,
   output int                                   evictions_seen
);
   import lfu_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_CAPACITY =
      CSR_ADDR_BITS'(4 * CSR_IDX_CAPACITY);

   logic [CAP_BITS-1:0]   capacity;
   logic                  entry_valid [CAPACITY];
   logic [DATA_BITS-1:0]  entry_key   [CAPACITY];
   logic [DATA_BITS-1:0]  entry_value [CAPACITY];
   logic [COUNT_BITS-1:0] use_count   [CAPACITY];
   int                    recency     [CAPACITY];
   lfu_rsp_type           expected_rsp_q [$];

   initial begin
      fail_count     = 0;
      pending        = 0;
      results_seen   = 0;
      hits_seen      = 0;
      evictions_seen = 0;
   end

   function automatic void promote(int e);
      int old_rank;
      old_rank = recency[e];
      for (int i = 0; i < CAPACITY; i++)
         if (entry_valid[i] && i != e && recency[i] < old_rank)
            recency[i]++;
      recency[e] = 0;
      if (use_count[e] != {COUNT_BITS{1'b1}})
         use_count[e]++;
   endfunction

   function automatic lfu_rsp_type lfu_access(logic cmd, logic [DATA_BITS-1:0] k,
                                              logic [DATA_BITS-1:0] v);
      lfu_rsp_type r;
      int found, slot, victim, used, limit, gone_rank;
      r.hit         = 1'b0;
      r.read_value  = '1;
      r.evicted     = 1'b0;
      r.evicted_key = '0;
      limit = (capacity > CAPACITY) ? CAPACITY : int'(capacity);
      found = -1;
      for (int i = 0; i < CAPACITY; i++)
         if (found < 0 && entry_valid[i] && entry_key[i] == k)
            found = i;
      r.hit = (found >= 0);
      if (cmd == CMD_GET) begin
         if (found >= 0) begin
            r.read_value = entry_value[found];
            promote(found);
         end
      end else if (limit != 0) begin
         if (found >= 0) begin
            entry_value[found] = v;
            promote(found);
         end else begin
            used = 0;
            slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
               if (entry_valid[i])
                  used++;
               else if (slot < 0)
                  slot = i;
            end
            if (used >= limit) begin
               victim = -1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (entry_valid[i] && (victim < 0 || use_count[i] < use_count[victim] ||
                      (use_count[i] == use_count[victim] && recency[i] > recency[victim])))
                     victim = i;
               end
               if (victim >= 0) begin
                  gone_rank = recency[victim];
                  r.evicted = 1'b1;
                  r.evicted_key = entry_key[victim];
                  entry_valid[victim] = 1'b0;
                  for (int i = 0; i < CAPACITY; i++)
                     if (entry_valid[i] && recency[i] > gone_rank)
                        recency[i]--;
                  if (slot < 0 || victim < slot)
                     slot = victim;
               end
            end
            if (slot >= 0) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (entry_valid[i])
                     recency[i]++;
               entry_valid[slot] = 1'b1;
               entry_key[slot]   = k;
               entry_value[slot] = v;
               use_count[slot]   = COUNT_BITS'(1);
               recency[slot]     = 0;
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [DATA_BITS-1:0] want,
                              logic [DATA_BITS-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lfu_rsp_type want;
      if (reset) begin
         capacity = CAP_RESET;
         for (int i = 0; i < CAPACITY; i++)
            entry_valid[i] = 1'b0;
         expected_rsp_q.delete();
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               $error("Result arrived with no request outstanding.");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("hit", DATA_BITS'(want.hit), DATA_BITS'(rsp_hit));
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("evicted", DATA_BITS'(want.evicted), DATA_BITS'(rsp_evicted));
               check_field("evicted_key", want.evicted_key, rsp_evicted_key);
               results_seen++;
               hits_seen += want.hit;
               evictions_seen += want.evicted;
            end
         end
         if (start && !busy)
            expected_rsp_q.push_back(lfu_access(req_command, req_key, req_value));
         if (psel && penable && pready && paddr == CSR_ADDR_CAPACITY) begin
            if (pwrite) begin
               capacity = pwdata[CAP_BITS-1:0];
            end else if (prdata !== CSR_DATA_BITS'(capacity)) begin
               $error("capacity_in_use mismatch: expected %h, got %h",
                      CSR_DATA_BITS'(capacity), prdata);
               fail_count++;
            end
         end
         pending <= expected_rsp_q.size();
      end
   end

endmodule

/* verif/testbench.sv */
// Top of the LFU cache table testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module testbench;
   import lfu_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_CAPACITY =
      CSR_ADDR_BITS'(4 * CSR_IDX_CAPACITY);
   localparam logic [DATA_BITS-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [DATA_BITS-1:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [DATA_BITS-1:0] WORD_ONES = 32'hffff_ffff;
   localparam int POOL_SIZE = 24;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_command = CMD_GET;
   logic signed [DATA_BITS-1:0]   req_key = '0;
   logic signed [DATA_BITS-1:0]   req_value = '0;
   logic                          rsp_strobe;
   logic                          rsp_hit;
   logic signed [DATA_BITS-1:0]   rsp_read_value;
   logic                          rsp_evicted;
   logic signed [DATA_BITS-1:0]   rsp_evicted_key;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   int fail_count, pending, results_seen, hits_seen, evictions_seen;
   int gap_percent = 0;
   int capacity_writes = 0;
   logic [DATA_BITS-1:0] key_pool [POOL_SIZE];

   always #6 clock = ~clock;

   lfu_cache_table u_dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_key, .req_value,
      .rsp_strobe, .rsp_hit, .rsp_read_value, .rsp_evicted, .rsp_evicted_key,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   lfu_table_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_command, .req_key, .req_value,
      .rsp_strobe, .rsp_hit, .rsp_read_value, .rsp_evicted, .rsp_evicted_key,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .fail_count, .pending, .results_seen, .hits_seen, .evictions_seen
   );

   task automatic send(logic cmd, logic [DATA_BITS-1:0] k, logic [DATA_BITS-1:0] v);
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_key     <= k;
      req_value   <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // The register is written, then read back so the checker can compare it.
   task automatic set_capacity(logic [CAP_BITS-1:0] cap);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_CAPACITY;
      pwdata  <= {(CSR_DATA_BITS - CAP_BITS)'($urandom()), cap};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      capacity_writes++;
   endtask

   function automatic logic [DATA_BITS-1:0] pick_key();
      if ($urandom_range(99) < 85)
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom();
   endfunction

   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      int unsigned phase_cap [9] = '{16, 4, 1, 0, 31, 2, 9, 16, 3};
      int          phase_gap [9] = '{0, 75, 16, 0, 75, 0, 16, 75, 16};
      key_pool[0] = WORD_MIN;
      key_pool[1] = WORD_MAX;
      key_pool[2] = WORD_ONES;
      key_pool[3] = '0;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme keys and values, hits, misses and updates at the reset capacity.
      send(CMD_GET, '0, WORD_ONES);
      send(CMD_PUT, WORD_MIN, WORD_MAX);
      send(CMD_PUT, WORD_MAX, WORD_MIN);
      send(CMD_PUT, WORD_ONES, '0);
      send(CMD_PUT, '0, WORD_ONES);
      send(CMD_GET, WORD_MIN, '0);
      send(CMD_GET, WORD_MAX, '0);
      send(CMD_GET, WORD_ONES, '0);
      send(CMD_GET, '0, '0);
      send(CMD_PUT, WORD_MAX, 32'd5);
      send(CMD_GET, WORD_MAX, '0);
      send(CMD_GET, 32'd1234, '0);
      // Capacity lowered below occupancy, then zero, then above the table size.
      set_capacity(5'd1);
      send(CMD_PUT, 32'd77, 32'd770);
      send(CMD_PUT, 32'd78, 32'd780);
      send(CMD_GET, 32'd77, '0);
      set_capacity(5'd0);
      send(CMD_PUT, WORD_MAX, 32'd9);
      send(CMD_PUT, 32'd999, 32'd1);
      send(CMD_GET, WORD_MAX, '0);
      send(CMD_GET, 32'd999, '0);
      set_capacity(5'd31);
      send(CMD_PUT, 32'd1000, WORD_MIN);
      send(CMD_GET, 32'd1000, '0);

      // At a small capacity the less used entry must be evicted before the busier one.
      set_capacity(5'd1);
      repeat (CAPACITY) send(CMD_PUT, $urandom(), $urandom());
      set_capacity(5'd2);
      send(CMD_PUT, 32'h5a5a_0001, 32'h1111_1111);
      send(CMD_GET, 32'h5a5a_0001, '0);
      send(CMD_PUT, 32'h5a5a_0002, 32'h2222_2222);
      send(CMD_PUT, 32'h5a5a_0003, 32'h3333_3333);

      for (int p = 0; p < 9; p++) begin
         set_capacity(CAP_BITS'(phase_cap[p]));
         gap_percent = phase_gap[p];
         repeat (78) send(1'($urandom_range(1)), pick_key(), $urandom());
      end
      gap_percent = 0;

      drain();
      repeat (6) @(posedge clock);
      $display("Checked %0d requests (%0d hits, %0d evictions) over %0d capacity writes,",
               results_seen, hits_seen, evictions_seen, capacity_writes);
      $display("including extreme keys, zero and oversized capacity, and eviction order.");
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
